// ===== hw/rtl/utf8_byte_sanitizer_defines.svh =====
// Assertion macros shared by the sanitizer RTL.
`ifndef UTF8_BYTE_SANITIZER_DEFINES_SVH
`define UTF8_BYTE_SANITIZER_DEFINES_SVH

// Invariant checked on every clock edge outside reset.
`define UBS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Implication checked in the same cycle as the antecedent.
`define UBS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ubs_pkg.sv =====
// Types and constants of the UTF-8 byte sanitizer.
package ubs_pkg;

  localparam logic [7:0] SUB_BYTE   = 8'h3F;  // '?'
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] ASCII_LIM  = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Sequence length codes
  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_ONE = 3'd1;

  // Up to four output bytes produced by one input beat
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
    logic            last;
  } grp_t;

  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    if (c < ASCII_LIM)                     len = LEN_ONE;
    else if ((c & LEAD2_MASK) == LEAD2_TAG) len = 3'd2;
    else if ((c & LEAD3_MASK) == LEAD3_TAG) len = 3'd3;
    else if ((c & LEAD4_MASK) == LEAD4_TAG) len = 3'd4;
    else                                    len = LEN_BAD;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c & CONT_MASK) == CONT_TAG;
  endfunction

endpackage

// ===== hw/rtl/utf8_byte_sanitizer.sv =====
// Top level of the streaming UTF-8 byte sanitiser.
//
//  channel | signals                        | beat carries
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready             | in_byte, in_last (raw byte)
//  out     | out_valid, out_ready           | out_byte, out_last (clean byte)
//
// One byte is taken per cycle while the group queue has room; one byte leaves
// per cycle while out_ready is high and a group is loaded. A byte inside an open
// multi-byte window is held until the window is judged; a completed group is
// queued and then registered in the output stage; a lead waits up to three further beats.
// Reset (rst, synchronous) empties the window, queue and output stage.
// in_ready drops only when QUEUE_DEPTH groups wait in the queue.
module utf8_byte_sanitizer #(
  parameter int QUEUE_DEPTH = 8  // groups buffered between front and back
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // front end -> queue
  logic          push;
  ubs_pkg::grp_t push_grp;
  logic          q_full;

  // queue -> back end
  logic          pop;
  logic          q_empty;
  ubs_pkg::grp_t head;

  // Scanner: classifies each beat against the held window and emits the
  // resolved bytes of that beat as one group (nothing if every byte is still held).
  ubs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .push_grp (push_grp)
  );

  // Decouples bursts of up to four bytes from the one-per-cycle output (while out_ready is high).
  ubs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_grp (push_grp),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  // Serialiser: registered group, one byte per beat, next group loaded on
  // the final beat so back-to-back groups leave without a gap.
  ubs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== hw/rtl/ubs_front.sv =====
// Front end: accepts bytes, scans the open window and forms output groups.
`include "utf8_byte_sanitizer_defines.svh"

module ubs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              push,
  output ubs_pkg::grp_t     push_grp
);

  // held bytes of an open window (lead first), no reset needed
  logic [7:0] held [3];
  logic [7:0] held_next [3];
  logic [1:0] held_cnt;
  logic [1:0] held_cnt_next;
  logic       past_term;
  logic       past_term_next;

  logic [7:0] s [4];
  logic [2:0] seq_n;
  logic [2:0] pos;
  logic [2:0] len;
  logic [2:0] idx;
  logic [2:0] hidx;
  logic       stop;
  logic       ok;
  logic [3:0] sub_scan;
  logic [3:0] sub;
  logic [2:0] k;
  logic       is_nul;
  logic       keep;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_nul   = in_byte == ubs_pkg::NUL_BYTE;

  // held bytes followed by the new one
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s[j] = (2'(j) == held_cnt) ? in_byte : held[j];
    end
    s[3]  = in_byte;
    seq_n = {1'b0, held_cnt} + 3'd1;
  end

  // rescanning scanner: each pass consumes one byte or one whole sequence, or stops at an open window
  always_comb begin
    pos      = 3'd0;
    stop     = 1'b0;
    sub_scan = 4'b0;
    len      = ubs_pkg::LEN_BAD;
    ok       = 1'b0;
    idx      = 3'd0;
    for (int it = 0; it < 4; it++) begin
      if (!stop && pos < seq_n) begin
        len = ubs_pkg::seq_len(s[pos[1:0]]);
        if (len == ubs_pkg::LEN_ONE) begin
          pos = pos + 3'd1;
        end else if (len == ubs_pkg::LEN_BAD) begin
          sub_scan[pos[1:0]] = 1'b1;
          pos = pos + 3'd1;
        end else if (pos + len > seq_n) begin
          stop = 1'b1;  // window still open
        end else begin
          ok = 1'b1;
          for (int j = 1; j < 4; j++) begin
            idx = pos + 3'(j);
            if (3'(j) < len && !ubs_pkg::is_cont(s[idx[1:0]])) begin
              ok = 1'b0;
            end
          end
          if (ok) begin
            pos = pos + len;
          end else begin
            sub_scan[pos[1:0]] = 1'b1;  // lead only, rest rescanned
            pos = pos + 3'd1;
          end
        end
      end
    end
  end

  always_comb begin
    if (past_term) begin
      k   = 3'd1;
      sub = 4'b0;
    end else if (is_nul) begin
      k = seq_n;
      for (int j = 0; j < 4; j++) begin
        sub[j] = 3'(j) < {1'b0, held_cnt};
      end
    end else if (in_last) begin
      k = seq_n;
      for (int j = 0; j < 4; j++) begin
        sub[j] = sub_scan[j] || (3'(j) >= pos);
      end
    end else begin
      k   = pos;
      sub = sub_scan;
    end
    for (int j = 0; j < 4; j++) begin
      push_grp.data[j] = sub[j] ? ubs_pkg::SUB_BYTE : s[j];
    end
    push_grp.cnt  = k;
    push_grp.last = in_last;
    push          = accept && (k != 3'd0);
  end

  always_comb begin
    keep          = !past_term && !is_nul && !in_last;
    held_cnt_next = keep ? 2'(seq_n - pos) : 2'd0;
    for (int j = 0; j < 3; j++) begin
      hidx         = pos + 3'(j);
      held_next[j] = s[hidx[1:0]];
    end
    if (in_last) begin
      past_term_next = 1'b0;
    end else if (is_nul) begin
      past_term_next = 1'b1;
    end else begin
      past_term_next = past_term;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_cnt  <= 2'd0;
      past_term <= 1'b0;
    end else if (accept) begin
      held_cnt  <= held_cnt_next;
      past_term <= past_term_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < 3; j++) begin
        held[j] <= held_next[j];
      end
    end
  end

  `UBS_ASSERT_ALWAYS(a_term_no_window, !past_term || held_cnt == 2'd0, "window open past terminator")
  `UBS_ASSERT_IMPLY(a_last_emits, accept && in_last, push, "last beat produced no output")
  `UBS_ASSERT_IMPLY(a_nul_flush, accept && !past_term && is_nul, push_grp.cnt == seq_n, "NUL did not flush window")

endmodule

// ===== hw/rtl/ubs_queue.sv =====
// Small group queue between front end and serialiser.
module ubs_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ubs_pkg::grp_t push_grp,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output ubs_pkg::grp_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ubs_pkg::grp_t  mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_grp;
    end
  end

endmodule

// ===== hw/rtl/ubs_back.sv =====
// Back end: serialises queued groups, one byte per beat.
`include "utf8_byte_sanitizer_defines.svh"

module ubs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  ubs_pkg::grp_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  ubs_pkg::grp_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic          last_beat;
  logic          fire;

  assign last_beat = ({1'b0, idx} + 3'd1) == cur.cnt;
  assign fire      = cur_valid && out_ready;
  assign pop       = !q_empty && (!cur_valid || (fire && last_beat));

  assign out_valid = cur_valid;
  assign out_byte  = cur.data[idx];
  assign out_last  = cur.last && last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (fire) begin
      if (last_beat) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  `UBS_ASSERT_IMPLY(a_grp_nonempty, cur_valid, cur.cnt != 3'd0, "empty group loaded")
  `UBS_ASSERT_IMPLY(a_idx_in_grp, cur_valid, {1'b0, idx} < cur.cnt, "byte index past group end")

endmodule
